[sv/qmm_pkg.sv]
package qmm_pkg;

    localparam int DEF_COUNT_WIDTH = 16;

    localparam int SPEED_W  = 12;
    localparam int THR_W    = 12;
    localparam int CTRL_W   = 15;
    localparam int END_W    = 15;
    localparam int FIRST_W  = 14;
    localparam int MIX_W    = 17;
    localparam int ABS_W    = 16;
    localparam int QUOT_W   = 12;
    localparam int PROD_W   = ABS_W + QUOT_W;
    localparam int MOTOR_W  = 13;
    localparam int PHASE_W  = 3;
    localparam int ADDR_W   = 3;
    localparam int WDATA_W  = 14;
    localparam int NUM_MOTORS = 4;

    localparam logic [ADDR_W-1:0] REG_LIFT_THRESHOLD  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_LOW_IDLE        = 3'd1;
    localparam logic [ADDR_W-1:0] REG_HIGH_IDLE       = 3'd2;
    localparam logic [ADDR_W-1:0] REG_FIRST_PHASE_END = 3'd3;
    localparam logic [ADDR_W-1:0] REG_PHASE_LENGTH    = 3'd4;
    localparam logic [ADDR_W-1:0] REG_SPEED_LIMIT     = 3'd5;
    localparam logic [ADDR_W-1:0] REG_PWM_BASE        = 3'd6;

    localparam logic signed [THR_W-1:0] RST_LIFT_THRESHOLD  = 12'sd150;
    localparam logic [SPEED_W-1:0]      RST_LOW_IDLE        = 12'd150;
    localparam logic [SPEED_W-1:0]      RST_HIGH_IDLE       = 12'd300;
    localparam logic [FIRST_W-1:0]      RST_FIRST_PHASE_END = 14'd600;
    localparam logic [SPEED_W-1:0]      RST_PHASE_LENGTH    = 12'd200;
    localparam logic [SPEED_W-1:0]      RST_SPEED_LIMIT     = 12'd1500;
    localparam logic [SPEED_W-1:0]      RST_PWM_BASE        = 12'd1000;

    localparam logic [PHASE_W-1:0] PHASE_LOW_A  = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_HIGH_A = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_LOW_B  = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_HIGH_B = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_DONE   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_MAX,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

[sv/quad_motor_mixer_spool_top.sv]
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    tdata: throttle, roll, pitch, yaw; tuser: kind
// m_        out        m_tvalid/m_tready    tdata: motor_0..motor_3, spool_phase; tuser: scaled
// cfg_      in         cfg_wr_en            cfg_addr selects the register, cfg_wdata
//
// A control item passes through the states MIX, MAX and OUT without scaling, a lock
// item through MIX and OUT, and a scaled item also through MUL and DIV for each of
// the four motors in turn, in the shared multiplier and the shared restoring divider.
// Reset is synchronous and active low; there is no clearing pass.
// s_tready is high only while the sequencer is idle, from the cycle after each load;
// a waiting result does not block the next transaction, only the following load.
module quad_motor_mixer_spool_top #(
    parameter int COUNT_WIDTH = qmm_pkg::DEF_COUNT_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // throttle[11:0], roll[26:12], pitch[41:27], yaw[56:42], zero pad
    input  logic [63:0]                    s_tdata,
    // kind[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // motor_0[12:0], motor_1[25:13], motor_2[38:26], motor_3[51:39],
    // spool_phase[54:52], zero pad
    output logic [55:0]                    m_tdata,
    // scaled[0]
    output logic                           m_tuser,
    input  logic                           cfg_wr_en,
    input  logic [qmm_pkg::ADDR_W-1:0]     cfg_addr,
    input  logic [qmm_pkg::WDATA_W-1:0]    cfg_wdata
);

    localparam int CMP_W = (COUNT_WIDTH > qmm_pkg::END_W) ? COUNT_WIDTH : qmm_pkg::END_W;
    localparam int MIX_W = qmm_pkg::MIX_W;
    localparam int SPD_W = qmm_pkg::SPEED_W;
    localparam int NM    = qmm_pkg::NUM_MOTORS;

    qmm_pkg::state_t state_reg, state_next;

    logic signed [qmm_pkg::THR_W-1:0]  lift_reg;
    logic [SPD_W-1:0]                  low_idle_reg, high_idle_reg, phase_len_reg;
    logic [SPD_W-1:0]                  limit_reg, base_reg;
    logic [qmm_pkg::FIRST_W-1:0]       first_end_reg;

    logic [COUNT_WIDTH-1:0]            count_reg, count_next;
    logic [qmm_pkg::PHASE_W-1:0]       phase_reg, phase_next;
    logic [SPD_W-1:0]                  held_reg [NM];
    logic [SPD_W-1:0]                  held_next [NM];

    logic                              kind_reg;
    logic signed [qmm_pkg::THR_W-1:0]  thr_reg;
    logic signed [qmm_pkg::CTRL_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [MIX_W-1:0]           sp_reg [NM];
    logic signed [MIX_W-1:0]           sp_next [NM];
    logic [qmm_pkg::ABS_W-1:0]         mx_reg, mx_next;
    logic                              sc_reg, sc_next;
    logic [1:0]                        idx_reg, idx_next;

    logic                              m_tvalid_reg, m_tvalid_next;
    logic [55:0]                       m_tdata_reg, m_tdata_next;
    logic                              m_tuser_reg, m_tuser_next;

    logic                              accept, out_load;
    logic                              div_start, div_done;
    logic [qmm_pkg::PROD_W-1:0]        div_dividend;
    logic [qmm_pkg::QUOT_W-1:0]        div_quot;

    logic signed [MIX_W-1:0]           t_x, r_x, p_x, y_x;
    logic [CMP_W-1:0]                  c_x, e0, e1, e2, e3;
    logic [qmm_pkg::PHASE_W-1:0]       ph;
    logic                              use_low, use_high;
    logic [qmm_pkg::ABS_W-1:0]         abs_v [NM];
    logic [qmm_pkg::ABS_W-1:0]         mx_c;
    logic [MIX_W-1:0]                  spool_speed;
    logic [qmm_pkg::MOTOR_W-1:0]       motor_v [NM];

    assign accept   = s_tvalid && (state_reg == qmm_pkg::ST_IDLE);
    assign out_load = (state_reg == qmm_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);

    // Spool sequence: the phases are walked in order so that several can pass
    // within one item.
    always_comb begin
        c_x = CMP_W'(count_reg);
        e0  = CMP_W'(first_end_reg);
        e1  = e0 + CMP_W'(phase_len_reg);
        e2  = e1 + CMP_W'(phase_len_reg);
        e3  = e2 + CMP_W'(phase_len_reg);
        ph       = phase_reg;
        use_low  = 1'b0;
        use_high = 1'b0;
        if (ph == qmm_pkg::PHASE_LOW_A) begin
            if (c_x < e0) use_low = 1'b1;
            else          ph = qmm_pkg::PHASE_HIGH_A;
        end
        if (ph == qmm_pkg::PHASE_HIGH_A) begin
            if (c_x < e1) use_high = 1'b1;
            else          ph = qmm_pkg::PHASE_LOW_B;
        end
        if (ph == qmm_pkg::PHASE_LOW_B) begin
            if (c_x < e2) use_low = 1'b1;
            else          ph = qmm_pkg::PHASE_HIGH_B;
        end
        if (ph == qmm_pkg::PHASE_HIGH_B) begin
            if (c_x < e3) use_high = 1'b1;
            else          ph = qmm_pkg::PHASE_DONE;
        end else if (ph == qmm_pkg::PHASE_DONE) begin
            use_low = 1'b1;
        end
        spool_speed = use_high ? MIX_W'(high_idle_reg) : MIX_W'(low_idle_reg);
    end

    always_comb begin
        t_x = MIX_W'(thr_reg);
        r_x = MIX_W'(roll_reg);
        p_x = MIX_W'(pitch_reg);
        y_x = MIX_W'(yaw_reg);
        for (int i = 0; i < NM; i++) begin
            abs_v[i] = sp_reg[i][MIX_W-1] ? qmm_pkg::ABS_W'(-sp_reg[i])
                                          : qmm_pkg::ABS_W'(sp_reg[i]);
        end
        mx_c = abs_v[0];
        for (int i = 1; i < NM; i++) begin
            if (abs_v[i] > mx_c) mx_c = abs_v[i];
        end
        for (int i = 0; i < NM; i++) begin
            motor_v[i] = qmm_pkg::MOTOR_W'(held_reg[i]) + qmm_pkg::MOTOR_W'(base_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qmm_pkg::ST_IDLE: begin
                if (accept) state_next = qmm_pkg::ST_MIX;
            end
            qmm_pkg::ST_MIX: begin
                state_next = kind_reg ? qmm_pkg::ST_OUT : qmm_pkg::ST_MAX;
            end
            qmm_pkg::ST_MAX: begin
                state_next = (mx_c > qmm_pkg::ABS_W'(limit_reg)) ? qmm_pkg::ST_MUL
                                                                 : qmm_pkg::ST_OUT;
            end
            qmm_pkg::ST_MUL: begin
                state_next = qmm_pkg::ST_DIV;
            end
            qmm_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = (idx_reg == 2'(NM-1)) ? qmm_pkg::ST_OUT : qmm_pkg::ST_MUL;
                end
            end
            qmm_pkg::ST_OUT: begin
                if (out_load) state_next = qmm_pkg::ST_IDLE;
            end
            default: state_next = qmm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        count_next   = count_reg;
        phase_next   = phase_reg;
        held_next    = held_reg;
        sp_next      = sp_reg;
        mx_next      = mx_reg;
        sc_next      = sc_reg;
        idx_next     = idx_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            qmm_pkg::ST_MIX: begin
                sc_next = 1'b0;
                if (kind_reg) begin
                    count_next = '0;
                    phase_next = qmm_pkg::PHASE_LOW_A;
                end else if (thr_reg > lift_reg) begin
                    sp_next[0] = t_x + r_x - p_x + y_x;
                    sp_next[1] = t_x - r_x - p_x - y_x;
                    sp_next[2] = t_x - r_x + p_x + y_x;
                    sp_next[3] = t_x + r_x + p_x - y_x;
                end else begin
                    if (count_reg != {COUNT_WIDTH{1'b1}}) count_next = count_reg + 1'b1;
                    phase_next = ph;
                    for (int i = 0; i < NM; i++) begin
                        sp_next[i] = (use_low || use_high) ? spool_speed
                                                           : MIX_W'(held_reg[i]);
                    end
                end
            end
            qmm_pkg::ST_MAX: begin
                mx_next  = mx_c;
                idx_next = '0;
                if (mx_c > qmm_pkg::ABS_W'(limit_reg)) begin
                    sc_next = 1'b1;
                end else begin
                    for (int i = 0; i < NM; i++) begin
                        held_next[i] = sp_reg[i][MIX_W-1] ? '0 : sp_reg[i][SPD_W-1:0];
                    end
                end
            end
            qmm_pkg::ST_MUL: begin
                div_start = 1'b1;
                if (!sp_reg[idx_reg][MIX_W-1]) begin
                    div_dividend = qmm_pkg::PROD_W'(sp_reg[idx_reg][qmm_pkg::ABS_W-1:0])
                                 * qmm_pkg::PROD_W'(limit_reg);
                end
            end
            qmm_pkg::ST_DIV: begin
                if (div_done) begin
                    held_next[idx_reg] = div_quot;
                    idx_next = idx_reg + 1'b1;
                end
            end
            qmm_pkg::ST_OUT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = sc_reg;
                    if (kind_reg) begin
                        m_tdata_next = {1'b0, phase_reg,
                                        qmm_pkg::MOTOR_W'(base_reg), qmm_pkg::MOTOR_W'(base_reg),
                                        qmm_pkg::MOTOR_W'(base_reg), qmm_pkg::MOTOR_W'(base_reg)};
                    end else begin
                        m_tdata_next = {1'b0, phase_reg,
                                        motor_v[3], motor_v[2], motor_v[1], motor_v[0]};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    qmm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (mx_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= qmm_pkg::ST_IDLE;
            lift_reg      <= qmm_pkg::RST_LIFT_THRESHOLD;
            low_idle_reg  <= qmm_pkg::RST_LOW_IDLE;
            high_idle_reg <= qmm_pkg::RST_HIGH_IDLE;
            first_end_reg <= qmm_pkg::RST_FIRST_PHASE_END;
            phase_len_reg <= qmm_pkg::RST_PHASE_LENGTH;
            limit_reg     <= qmm_pkg::RST_SPEED_LIMIT;
            base_reg      <= qmm_pkg::RST_PWM_BASE;
            count_reg     <= '0;
            phase_reg     <= qmm_pkg::PHASE_LOW_A;
            for (int i = 0; i < NM; i++) held_reg[i] <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    qmm_pkg::REG_LIFT_THRESHOLD:  lift_reg      <= cfg_wdata[SPD_W-1:0];
                    qmm_pkg::REG_LOW_IDLE:        low_idle_reg  <= cfg_wdata[SPD_W-1:0];
                    qmm_pkg::REG_HIGH_IDLE:       high_idle_reg <= cfg_wdata[SPD_W-1:0];
                    qmm_pkg::REG_FIRST_PHASE_END: first_end_reg <= cfg_wdata;
                    qmm_pkg::REG_PHASE_LENGTH:    phase_len_reg <= cfg_wdata[SPD_W-1:0];
                    qmm_pkg::REG_SPEED_LIMIT:     limit_reg     <= cfg_wdata[SPD_W-1:0];
                    qmm_pkg::REG_PWM_BASE:        base_reg      <= cfg_wdata[SPD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        if (accept) begin
            kind_reg  <= s_tuser;
            thr_reg   <= s_tdata[11:0];
            roll_reg  <= s_tdata[26:12];
            pitch_reg <= s_tdata[41:27];
            yaw_reg   <= s_tdata[56:42];
        end
        sp_reg      <= sp_next;
        mx_reg      <= mx_next;
        sc_reg      <= sc_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == qmm_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[sv/qmm_div.sv]
module qmm_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [qmm_pkg::PROD_W-1:0]        dividend,
    input  logic [qmm_pkg::ABS_W-1:0]         divisor,
    output logic                              done,
    output logic [qmm_pkg::QUOT_W-1:0]        quotient
);

    localparam int CNT_W = $clog2(qmm_pkg::QUOT_W);
    localparam int DSH_W = qmm_pkg::ABS_W + qmm_pkg::QUOT_W - 1;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [qmm_pkg::PROD_W-1:0]    rem_reg, rem_next;
    logic [DSH_W-1:0]              dsh_reg, dsh_next;
    logic [qmm_pkg::QUOT_W-1:0]    quot_reg, quot_next;
    logic                          fits;

    // The quotient is known to stay below 2**QUOT_W, so the divisor starts
    // shifted up by QUOT_W-1 places and one quotient bit is settled per cycle.
    always_comb begin
        fits      = (rem_reg >= qmm_pkg::PROD_W'(dsh_reg));
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend;
            dsh_next  = {divisor, {(qmm_pkg::QUOT_W-1){1'b0}}};
            quot_next = '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - qmm_pkg::PROD_W'(dsh_reg);
            end
            quot_next = {quot_reg[qmm_pkg::QUOT_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(qmm_pkg::QUOT_W-1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

[verif/quad_motor_mixer_spool_top_tb.sv]
module quad_motor_mixer_spool_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_CTRL = 1'b0;
    localparam logic KIND_LOCK = 1'b1;
    localparam logic [qmm_pkg::ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam int NUM_SETTINGS = 10;
    localparam int ITEMS_PER_SETTING = 40;

    typedef struct packed {
        logic                               kind;
        logic signed [qmm_pkg::THR_W-1:0]   throttle;
        logic signed [qmm_pkg::CTRL_W-1:0]  roll;
        logic signed [qmm_pkg::CTRL_W-1:0]  pitch;
        logic signed [qmm_pkg::CTRL_W-1:0]  yaw;
    } ctrl_item_t;

    typedef struct packed {
        logic [qmm_pkg::NUM_MOTORS-1:0][qmm_pkg::MOTOR_W-1:0] motor;
        logic [qmm_pkg::PHASE_W-1:0]                          phase;
        logic                                                 scaled;
    } motor_set_t;

    typedef struct packed {
        logic                          cfg;
        logic [qmm_pkg::ADDR_W-1:0]    addr;
        logic [qmm_pkg::WDATA_W-1:0]   wdata;
        ctrl_item_t                    item;
        logic                          typed;
        logic [qmm_pkg::MOTOR_W-1:0]   motor;
        logic [qmm_pkg::PHASE_W-1:0]   phase;
        logic                          scaled;
    } plan_row_t;

    // Columns: cfg, addr, wdata, {kind, throttle, roll, pitch, yaw}, typed, motor, phase, scaled.
    localparam plan_row_t DIRECTED_PLAN [23] = '{
        '{0, 0, 0, '{KIND_CTRL, 0, 0, 0, 0}, 1, 1150, qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_LOCK, -2048, 16383, -16384, 16383}, 1, 1000, qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_CTRL, 2047, 0, 0, 0}, 1, 2500, qmm_pkg::PHASE_LOW_A, 1},
        '{0, 0, 0, '{KIND_CTRL, 1000, 0, 0, 0}, 1, 2000, qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_CTRL, 150, 0, 0, 0}, 1, 1150, qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_CTRL, 151, 1, 0, 0}, 0, 0, qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_CTRL, 2047, 16383, -16384, 16383}, 0, 0, qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_CTRL, 2047, -16384, 16383, -16384}, 0, 0, qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_CTRL, -2048, -16384, -16384, -16384}, 0, 0, qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_CTRL, 300, -400, 0, 0}, 0, 0, qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_CTRL, 2047, 0, 0, 16383}, 0, 0, qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_LOCK, 0, 0, 0, 0}, 1, 1000, qmm_pkg::PHASE_LOW_A, 0},
        '{1, qmm_pkg::REG_FIRST_PHASE_END, 0, '{KIND_CTRL, 0, 0, 0, 0}, 0, 0,
          qmm_pkg::PHASE_LOW_A, 0},
        '{1, qmm_pkg::REG_PHASE_LENGTH, 0, '{KIND_CTRL, 0, 0, 0, 0}, 0, 0,
          qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_CTRL, 0, 0, 0, 0}, 0, 0, qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_CTRL, 0, 0, 0, 0}, 0, 0, qmm_pkg::PHASE_LOW_A, 0},
        '{1, qmm_pkg::REG_SPEED_LIMIT, 4096, '{KIND_CTRL, 0, 0, 0, 0}, 0, 0,
          qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_CTRL, 0, 0, 0, 0}, 1, 1000, qmm_pkg::PHASE_DONE, 1},
        '{0, 0, 0, '{KIND_CTRL, 2047, 16383, 16383, 16383}, 1, 1000, qmm_pkg::PHASE_DONE, 1},
        '{1, qmm_pkg::REG_SPEED_LIMIT, 1500, '{KIND_CTRL, 0, 0, 0, 0}, 0, 0,
          qmm_pkg::PHASE_LOW_A, 0},
        '{1, REG_UNUSED, 16383, '{KIND_CTRL, 0, 0, 0, 0}, 0, 0, qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_LOCK, 0, 0, 0, 0}, 1, 1000, qmm_pkg::PHASE_LOW_A, 0},
        '{0, 0, 0, '{KIND_CTRL, 0, 0, 0, 0}, 0, 0, qmm_pkg::PHASE_LOW_A, 0}
    };

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [63:0]                    s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [55:0]                    m_tdata;
    logic                           m_tuser;
    logic                           cfg_wr_en = 1'b0;
    logic [qmm_pkg::ADDR_W-1:0]     cfg_addr = '0;
    logic [qmm_pkg::WDATA_W-1:0]    cfg_wdata = '0;

    quad_motor_mixer_spool_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    logic signed [qmm_pkg::THR_W-1:0]       lift_thr;
    logic [qmm_pkg::SPEED_W-1:0]            low_idle_spd;
    logic [qmm_pkg::SPEED_W-1:0]            high_idle_spd;
    logic [qmm_pkg::FIRST_W-1:0]            first_end;
    logic [qmm_pkg::SPEED_W-1:0]            phase_len;
    logic [qmm_pkg::SPEED_W-1:0]            speed_lim;
    logic [qmm_pkg::SPEED_W-1:0]            pwm_base_val;
    logic [qmm_pkg::DEF_COUNT_WIDTH-1:0]    step_count;
    logic [qmm_pkg::PHASE_W-1:0]            spool_phase;
    logic [qmm_pkg::SPEED_W-1:0]            held_speed [qmm_pkg::NUM_MOTORS];

    motor_set_t   pending_motor_sets [$];
    int unsigned  mismatches = 0;
    int unsigned  results_seen = 0;
    int unsigned  ready_hold = 0;
    bit           long_hold_done = 1'b0;
    bit           quiet = 1'b0;

    function automatic void apply_setting(logic [qmm_pkg::ADDR_W-1:0] idx,
                                          logic [qmm_pkg::WDATA_W-1:0] val);
        case (idx)
            qmm_pkg::REG_LIFT_THRESHOLD:  lift_thr = val[qmm_pkg::THR_W-1:0];
            qmm_pkg::REG_LOW_IDLE:        low_idle_spd = val[qmm_pkg::SPEED_W-1:0];
            qmm_pkg::REG_HIGH_IDLE:       high_idle_spd = val[qmm_pkg::SPEED_W-1:0];
            qmm_pkg::REG_FIRST_PHASE_END: first_end = val[qmm_pkg::FIRST_W-1:0];
            qmm_pkg::REG_PHASE_LENGTH:    phase_len = val[qmm_pkg::SPEED_W-1:0];
            qmm_pkg::REG_SPEED_LIMIT:     speed_lim = val[qmm_pkg::SPEED_W-1:0];
            qmm_pkg::REG_PWM_BASE:        pwm_base_val = val[qmm_pkg::SPEED_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic motor_set_t mix_and_spool(ctrl_item_t it);
        motor_set_t res;
        longint sp [qmm_pkg::NUM_MOTORS];
        longint t, r, p, y, c, e0, e1, e2, e3, fill, peak, mag;
        bit filled;
        res = '0;
        if (it.kind == KIND_LOCK) begin
            step_count = '0;
            spool_phase = qmm_pkg::PHASE_LOW_A;
            for (int i = 0; i < qmm_pkg::NUM_MOTORS; i++) begin
                res.motor[i] = qmm_pkg::MOTOR_W'(pwm_base_val);
            end
            res.phase = qmm_pkg::PHASE_LOW_A;
            return res;
        end
        t = longint'(it.throttle);
        r = longint'(it.roll);
        p = longint'(it.pitch);
        y = longint'(it.yaw);
        for (int i = 0; i < qmm_pkg::NUM_MOTORS; i++) sp[i] = longint'(held_speed[i]);
        if (t > longint'(lift_thr)) begin
            sp[0] = t + r - p + y;
            sp[1] = t - r - p - y;
            sp[2] = t - r + p + y;
            sp[3] = t + r + p - y;
        end else begin
            c = longint'(step_count);
            e0 = longint'(first_end);
            e1 = e0 + longint'(phase_len);
            e2 = e1 + longint'(phase_len);
            e3 = e2 + longint'(phase_len);
            if (step_count != '1) step_count = step_count + 1'b1;
            filled = 1'b0;
            fill = 0;
            if (spool_phase == qmm_pkg::PHASE_LOW_A) begin
                if (c < e0) begin
                    filled = 1'b1;
                    fill = longint'(low_idle_spd);
                end else spool_phase = qmm_pkg::PHASE_HIGH_A;
            end
            if (spool_phase == qmm_pkg::PHASE_HIGH_A) begin
                if (c < e1) begin
                    filled = 1'b1;
                    fill = longint'(high_idle_spd);
                end else spool_phase = qmm_pkg::PHASE_LOW_B;
            end
            if (spool_phase == qmm_pkg::PHASE_LOW_B) begin
                if (c < e2) begin
                    filled = 1'b1;
                    fill = longint'(low_idle_spd);
                end else spool_phase = qmm_pkg::PHASE_HIGH_B;
            end
            if (spool_phase == qmm_pkg::PHASE_HIGH_B) begin
                if (c < e3) begin
                    filled = 1'b1;
                    fill = longint'(high_idle_spd);
                end else spool_phase = qmm_pkg::PHASE_DONE;
            end else if (spool_phase == qmm_pkg::PHASE_DONE) begin
                filled = 1'b1;
                fill = longint'(low_idle_spd);
            end
            if (filled) for (int i = 0; i < qmm_pkg::NUM_MOTORS; i++) sp[i] = fill;
        end
        peak = 0;
        for (int i = 0; i < qmm_pkg::NUM_MOTORS; i++) begin
            mag = (sp[i] < 0) ? -sp[i] : sp[i];
            if (mag > peak) peak = mag;
        end
        if (peak > longint'(speed_lim)) begin
            res.scaled = 1'b1;
            for (int i = 0; i < qmm_pkg::NUM_MOTORS; i++) begin
                sp[i] = (sp[i] * longint'(speed_lim)) / peak;
            end
        end
        for (int i = 0; i < qmm_pkg::NUM_MOTORS; i++) begin
            if (sp[i] < 0) sp[i] = 0;
            held_speed[i] = sp[i][qmm_pkg::SPEED_W-1:0];
            res.motor[i] = qmm_pkg::MOTOR_W'(longint'(held_speed[i]) + longint'(pwm_base_val));
        end
        res.phase = spool_phase;
        return res;
    endfunction

    function automatic logic [qmm_pkg::CTRL_W-1:0] random_correction();
        if ($urandom_range(0, 1) == 0) return qmm_pkg::CTRL_W'($urandom);
        return qmm_pkg::CTRL_W'($urandom_range(0, 600) - 300);
    endfunction

    function automatic ctrl_item_t random_item();
        ctrl_item_t it;
        int pick, span;
        pick = $urandom_range(0, 99);
        it.kind = (pick < 3) ? KIND_LOCK : KIND_CTRL;
        if (pick < 10) begin
            it.throttle = qmm_pkg::THR_W'($urandom);
        end else if (pick < 65) begin
            span = int'(lift_thr) + 2048;
            it.throttle = qmm_pkg::THR_W'($urandom_range(0, span) - 2048);
        end else begin
            span = 2047 - int'(lift_thr);
            if (span == 0) it.throttle = qmm_pkg::THR_W'($urandom);
            else it.throttle = qmm_pkg::THR_W'(int'(lift_thr) + 1 + $urandom_range(0, span - 1));
        end
        it.roll = random_correction();
        it.pitch = random_correction();
        it.yaw = random_correction();
        return it;
    endfunction

    task automatic settle();
        cfg_wr_en <= 1'b0;
        s_tvalid <= 1'b0;
        while (pending_motor_sets.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [qmm_pkg::ADDR_W-1:0] idx, logic [qmm_pkg::WDATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        apply_setting(idx, val);
    endtask

    task automatic push_item(ctrl_item_t it, bit typed, motor_set_t typed_set);
        motor_set_t predicted;
        cfg_wr_en <= 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {7'b0, it.yaw, it.pitch, it.roll, it.throttle};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = mix_and_spool(it);
        pending_motor_sets.push_back(typed ? typed_set : predicted);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (!long_hold_done && results_seen >= 110) begin
            m_tready <= 1'b0;
            ready_hold <= 249;
            long_hold_done <= 1'b1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        motor_set_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (pending_motor_sets.size() == 0) begin
                $error("Unexpected result transaction: tdata %h, tuser %b", m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_motor_sets.pop_front();
                for (int i = 0; i < qmm_pkg::NUM_MOTORS; i++) begin
                    if (m_tdata[i*qmm_pkg::MOTOR_W +: qmm_pkg::MOTOR_W] !== want.motor[i]) begin
                        $error("motor_%0d: expected %0d, actual %0d", i, want.motor[i],
                               m_tdata[i*qmm_pkg::MOTOR_W +: qmm_pkg::MOTOR_W]);
                        mismatches++;
                    end
                end
                if (m_tdata[54:52] !== want.phase) begin
                    $error("spool_phase: expected %0d, actual %0d", want.phase, m_tdata[54:52]);
                    mismatches++;
                end
                if (m_tuser !== want.scaled) begin
                    $error("scaled: expected %0d, actual %0d", want.scaled, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        motor_set_t typed_set;
        logic [qmm_pkg::WDATA_W-1:0] lift_w, low_w, high_w, first_w, len_w, lim_w, base_w;
        lift_thr = qmm_pkg::RST_LIFT_THRESHOLD;
        low_idle_spd = qmm_pkg::RST_LOW_IDLE;
        high_idle_spd = qmm_pkg::RST_HIGH_IDLE;
        first_end = qmm_pkg::RST_FIRST_PHASE_END;
        phase_len = qmm_pkg::RST_PHASE_LENGTH;
        speed_lim = qmm_pkg::RST_SPEED_LIMIT;
        pwm_base_val = qmm_pkg::RST_PWM_BASE;
        step_count = '0;
        spool_phase = qmm_pkg::PHASE_LOW_A;
        for (int i = 0; i < qmm_pkg::NUM_MOTORS; i++) held_speed[i] = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_PLAN[n]) begin
            if (DIRECTED_PLAN[n].cfg) begin
                settle();
                write_reg(DIRECTED_PLAN[n].addr, DIRECTED_PLAN[n].wdata);
            end else begin
                for (int i = 0; i < qmm_pkg::NUM_MOTORS; i++) begin
                    typed_set.motor[i] = DIRECTED_PLAN[n].motor;
                end
                typed_set.phase = DIRECTED_PLAN[n].phase;
                typed_set.scaled = DIRECTED_PLAN[n].scaled;
                push_item(DIRECTED_PLAN[n].item, DIRECTED_PLAN[n].typed, typed_set);
            end
        end

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            lift_w = (s == 1) ? qmm_pkg::WDATA_W'(-2048) :
                     (s == 2) ? qmm_pkg::WDATA_W'(2047) :
                     qmm_pkg::WDATA_W'($urandom_range(0, 700) - 200);
            low_w  = (s == 3) ? '0 : (s == 4) ? qmm_pkg::WDATA_W'(4095) :
                     qmm_pkg::WDATA_W'($urandom);
            high_w = (s == 3) ? qmm_pkg::WDATA_W'(4095) : (s == 4) ? '0 :
                     qmm_pkg::WDATA_W'($urandom);
            first_w = (s == 5) ? qmm_pkg::WDATA_W'(16383) :
                      (s == 6) ? '0 : qmm_pkg::WDATA_W'($urandom_range(0, 10));
            len_w = (s == 5) ? qmm_pkg::WDATA_W'(16383) : (s == 6) ? qmm_pkg::WDATA_W'(4096) :
                    qmm_pkg::WDATA_W'(($urandom_range(0, 3) << 12) | $urandom_range(0, 5));
            lim_w = (s == 0) ? qmm_pkg::WDATA_W'(4096) : (s == 7) ? qmm_pkg::WDATA_W'(1) :
                    (s == 8) ? qmm_pkg::WDATA_W'(4095) :
                    qmm_pkg::WDATA_W'($urandom_range(1, 4095));
            base_w = (s == 1) ? '0 : (s == 2) ? qmm_pkg::WDATA_W'(4095) :
                     qmm_pkg::WDATA_W'($urandom);
            settle();
            write_reg(qmm_pkg::REG_LIFT_THRESHOLD, lift_w);
            write_reg(qmm_pkg::REG_LOW_IDLE, low_w);
            write_reg(qmm_pkg::REG_HIGH_IDLE, high_w);
            write_reg(qmm_pkg::REG_FIRST_PHASE_END, first_w);
            write_reg(qmm_pkg::REG_PHASE_LENGTH, len_w);
            write_reg(qmm_pkg::REG_SPEED_LIMIT, lim_w);
            write_reg(qmm_pkg::REG_PWM_BASE, base_w);
            if (s == 0) write_reg(REG_UNUSED, qmm_pkg::WDATA_W'($urandom));
            quiet = (s == NUM_SETTINGS - 1);
            for (int k = 0; k < ITEMS_PER_SETTING; k++) push_item(random_item(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_motor_sets.size() != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/qmm_pkg.sv
sv/qmm_div.sv
sv/quad_motor_mixer_spool_top.sv
verif/quad_motor_mixer_spool_top_tb.sv
